[design/pbot_pkg.sv]
// ----------------------------------------------------------------------------
// pbot_pkg
// Shared types and constants for the pulse / blink output timer.
// ----------------------------------------------------------------------------
package pbot_pkg;

  // Field widths of the timestamp and of the driven value.
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned VALUE_BITS = 8;

  // Register map: index of each configuration register.
  localparam int unsigned REG_COUNT = 6;
  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned IDX_BITS  = 3;

  typedef enum logic [IDX_BITS-1:0] {
    REG_POLL_CLASS_SEL = 3'd0,
    REG_ON_TIME        = 3'd1,
    REG_OFF_TIME       = 3'd2,
    REG_ON_VALUE       = 3'd3,
    REG_OFF_VALUE      = 3'd4,
    REG_INVERT         = 3'd5
  } reg_idx_t;

  // Actions carried by an input item.
  typedef enum logic [2:0] {
    ACT_POLL         = 3'd0,
    ACT_START_SINGLE = 3'd1,
    ACT_START_REPEAT = 3'd2,
    ACT_STOP         = 3'd3,
    ACT_SET_VALUE    = 3'd4
  } action_t;

  // Generator phase.
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ONCE_ON  = 3'd1,
    PH_ONCE_OFF = 3'd2,
    PH_REP_ON   = 3'd3,
    PH_REP_OFF  = 3'd4
  } phase_t;

  // Input item.
  typedef struct packed {
    logic [2:0]            action;
    logic [TIME_BITS-1:0]  now_us;
    logic [1:0]            poll_class;
    logic [VALUE_BITS-1:0] new_value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [VALUE_BITS-1:0] out_value;
    logic                  pin_level;
    logic                  changed;
    logic [2:0]            phase;
  } out_item_t;

endpackage

[design/pulse_blink_output_timer.sv]
// ----------------------------------------------------------------------------
// pulse_blink_output_timer
// One output channel driven directly or by a single-pulse / blink generator.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                               Moves
//   -------   ---------------------------------   ------------------------
//   input     in_valid, in_ready, in_data         one action with timestamp
//   result    out_valid, out_ready, out_data      value, pin, changed, phase
//   config    psel, penable, pwrite, paddr, ...   register writes and reads
//
// Each input transfer lands in an input register; when the output register
// frees up, the generator state is updated and the result is loaded into it,
// so one item is taken every cycle unless the output register stalls.
// A stalled output register holds its result while the input register
// still takes one more item; the input side stalls only when both are full.
// The synchronous active-low reset idles the generator and loads the
// register reset values.
// ----------------------------------------------------------------------------
module pulse_blink_output_timer (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  pbot_pkg::in_item_t                in_data,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output pbot_pkg::out_item_t               out_data,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pbot_pkg::ADDR_BITS-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // Configuration registers.
  logic [1:0]                      poll_class_sel_r;
  logic [pbot_pkg::TIME_BITS-1:0]  on_time_r;
  logic [pbot_pkg::TIME_BITS-1:0]  off_time_r;
  logic [pbot_pkg::VALUE_BITS-1:0] on_value_r;
  logic [pbot_pkg::VALUE_BITS-1:0] off_value_r;
  logic                            invert_r;

  // Generator state.
  pbot_pkg::phase_t                run_mode_r, run_mode_nxt;
  logic [pbot_pkg::TIME_BITS-1:0]  phase_start_r, phase_start_nxt;
  logic [pbot_pkg::VALUE_BITS-1:0] cur_value_r, cur_value_nxt;
  logic                            changed_nxt;

  // Pipeline registers.
  logic                            s1_valid_r;
  pbot_pkg::in_item_t              s1_data_r;
  logic                            out_valid_r;
  pbot_pkg::out_item_t             out_data_r;

  logic                            cfg_wr;
  pbot_pkg::reg_idx_t              cfg_idx;
  logic                            out_free;
  logic                            s1_move;

  // Decoded work of the item in the input register.
  pbot_pkg::action_t               act;
  logic                            poll_hit;
  logic                            on_phase;
  logic [pbot_pkg::TIME_BITS-1:0]  limit;
  logic [pbot_pkg::TIME_BITS-1:0]  elapsed;
  logic                            expired;
  logic [pbot_pkg::VALUE_BITS-1:0] want;

  // Configuration port: writes complete in the access cycle.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = pbot_pkg::reg_idx_t'(paddr[pbot_pkg::ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_class_sel_r <= '0;
      on_time_r        <= '0;
      off_time_r       <= '0;
      on_value_r       <= pbot_pkg::VALUE_BITS'(1);
      off_value_r      <= '0;
      invert_r         <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pbot_pkg::REG_POLL_CLASS_SEL: poll_class_sel_r <= pwdata[1:0];
        pbot_pkg::REG_ON_TIME:        on_time_r   <= pwdata[pbot_pkg::TIME_BITS-1:0];
        pbot_pkg::REG_OFF_TIME:       off_time_r  <= pwdata[pbot_pkg::TIME_BITS-1:0];
        pbot_pkg::REG_ON_VALUE:       on_value_r  <= pwdata[pbot_pkg::VALUE_BITS-1:0];
        pbot_pkg::REG_OFF_VALUE:      off_value_r <= pwdata[pbot_pkg::VALUE_BITS-1:0];
        pbot_pkg::REG_INVERT:         invert_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      pbot_pkg::REG_POLL_CLASS_SEL: prdata = 32'(poll_class_sel_r);
      pbot_pkg::REG_ON_TIME:        prdata = 32'(on_time_r);
      pbot_pkg::REG_OFF_TIME:       prdata = 32'(off_time_r);
      pbot_pkg::REG_ON_VALUE:       prdata = 32'(on_value_r);
      pbot_pkg::REG_OFF_VALUE:      prdata = 32'(off_value_r);
      pbot_pkg::REG_INVERT:         prdata = 32'(invert_r);
      default:                      prdata = '0;
    endcase
  end

  // Handshake: the output register frees up when empty or when taken.
  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // Timing of the current phase against its duration.
  assign act      = pbot_pkg::action_t'(s1_data_r.action);
  assign poll_hit = (act == pbot_pkg::ACT_POLL) &&
                    (s1_data_r.poll_class == poll_class_sel_r) &&
                    (run_mode_r != pbot_pkg::PH_IDLE);
  assign on_phase = (run_mode_r == pbot_pkg::PH_ONCE_ON) ||
                    (run_mode_r == pbot_pkg::PH_REP_ON);
  assign limit    = on_phase ? on_time_r : off_time_r;
  assign elapsed  = s1_data_r.now_us - phase_start_r;
  assign expired  = (elapsed >= limit);

  // Next phase and phase start.
  always_comb begin
    run_mode_nxt    = run_mode_r;
    phase_start_nxt = phase_start_r;
    case (act)
      pbot_pkg::ACT_POLL: begin
        if (poll_hit && expired) begin
          phase_start_nxt = s1_data_r.now_us;
          unique case (run_mode_r)
            pbot_pkg::PH_ONCE_ON:  run_mode_nxt = pbot_pkg::PH_ONCE_OFF;
            pbot_pkg::PH_ONCE_OFF: run_mode_nxt = pbot_pkg::PH_IDLE;
            pbot_pkg::PH_REP_ON:   run_mode_nxt = pbot_pkg::PH_REP_OFF;
            pbot_pkg::PH_REP_OFF:  run_mode_nxt = pbot_pkg::PH_REP_ON;
            default:               run_mode_nxt = run_mode_r;
          endcase
        end
      end
      pbot_pkg::ACT_START_SINGLE: begin
        run_mode_nxt    = pbot_pkg::PH_ONCE_ON;
        phase_start_nxt = s1_data_r.now_us;
      end
      pbot_pkg::ACT_START_REPEAT: begin
        run_mode_nxt    = pbot_pkg::PH_REP_ON;
        phase_start_nxt = s1_data_r.now_us;
      end
      pbot_pkg::ACT_STOP: run_mode_nxt = pbot_pkg::PH_IDLE;
      default: ;
    endcase
  end

  // Value the phase wants, and the driven value. The end of a single
  // pulse still wants the off value on its way to idle.
  always_comb begin
    want = on_phase ? on_value_r : off_value_r;
    if (poll_hit && expired) begin
      case (run_mode_r)
        pbot_pkg::PH_ONCE_ON, pbot_pkg::PH_REP_ON: want = off_value_r;
        pbot_pkg::PH_REP_OFF:                      want = on_value_r;
        default:                                   want = off_value_r;
      endcase
    end
  end

  always_comb begin
    cur_value_nxt = cur_value_r;
    changed_nxt   = 1'b0;
    case (act)
      pbot_pkg::ACT_POLL: begin
        if (poll_hit && (want != cur_value_r)) begin
          cur_value_nxt = want;
          changed_nxt   = 1'b1;
        end
      end
      pbot_pkg::ACT_START_SINGLE, pbot_pkg::ACT_START_REPEAT: begin
        if (on_value_r != cur_value_r) begin
          cur_value_nxt = on_value_r;
          changed_nxt   = 1'b1;
        end
      end
      pbot_pkg::ACT_SET_VALUE: begin
        cur_value_nxt = s1_data_r.new_value;
        changed_nxt   = 1'b1;
      end
      default: ;
    endcase
  end

  // Generator state advances once per item leaving the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_mode_r    <= pbot_pkg::PH_IDLE;
      phase_start_r <= '0;
      cur_value_r   <= '0;
    end else if (s1_move) begin
      run_mode_r    <= run_mode_nxt;
      phase_start_r <= phase_start_nxt;
      cur_value_r   <= cur_value_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r.out_value <= cur_value_nxt;
      out_data_r.pin_level <= (cur_value_nxt != '0) ^ invert_r;
      out_data_r.changed   <= changed_nxt;
      out_data_r.phase     <= run_mode_nxt;
    end
  end

  // An item held in the input register waits while the output stalls.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("input register dropped an item while the output stalled");

  // The latest result reports the phase the generator now holds.
  a_phase_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_data_r.phase == run_mode_r)
    else $error("result phase differs from generator state");

  // The latest result reports the value the channel now drives.
  a_value_match: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move |=> out_data_r.out_value == cur_value_r)
    else $error("result value differs from driven value");

  // Stop never writes a value.
  a_stop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_move && (act == pbot_pkg::ACT_STOP) |=> !out_data_r.changed)
    else $error("stop action reported a value write");

endmodule

[tb/sv/pulse_blink_output_timer_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pulse_blink_output_timer_test
// Self-checking test of the pulse / blink output timer. Each input transfer
// runs through a cycle-free model of the channel, and the expected result is
// queued. Every result transfer is compared field by field with the oldest
// queued result. Directed items cover the special cases. Random bursts then
// run under several register settings, with random gaps on both sides, a
// long receiver stall and a full drain pause.
// ----------------------------------------------------------------------------
module pulse_blink_output_timer_test;
  import pbot_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // Clock, reset and the block's inputs, all known from time zero.
  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 psel      = 1'b0;
  logic                 penable   = 1'b0;
  logic                 pwrite    = 1'b0;
  logic [ADDR_BITS-1:0] paddr     = '0;
  logic [31:0]          pwdata    = '0;
  logic [31:0]          prdata;
  logic                 pready;

  // Register copies and channel state used for prediction.
  logic [1:0]            cfg_sel     = 2'd0;
  logic [TIME_BITS-1:0]  cfg_on_time = '0;
  logic [TIME_BITS-1:0]  cfg_off_time = '0;
  logic [VALUE_BITS-1:0] cfg_on_val  = 8'd1;
  logic [VALUE_BITS-1:0] cfg_off_val = 8'd0;
  logic                  cfg_invert  = 1'b0;
  phase_t                gen_phase   = PH_IDLE;
  logic [TIME_BITS-1:0]  gen_start   = '0;
  logic [VALUE_BITS-1:0] drv_value   = '0;

  out_item_t            pending_outputs[$];
  out_item_t            want_item;
  logic [TIME_BITS-1:0] now_cur = '0;
  bit                   no_gaps = 1'b0;
  int                   hold_req = 0;
  int                   hold_left = 0;
  int                   idle_cycles = 0;
  int                   errors = 0;
  int                   n_sent = 0;
  int                   n_checked = 0;
  int                   n_writes = 0;
  int                   n_settings = 0;

  pulse_blink_output_timer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Next channel state and result for one input item.
  function automatic out_item_t channel_next(input in_item_t it);
    out_item_t             r;
    logic                  chg;
    logic                  on_ph;
    logic [TIME_BITS-1:0]  lim;
    logic [TIME_BITS-1:0]  elapsed;
    logic [VALUE_BITS-1:0] want;
    chg = 1'b0;
    case (it.action)
      ACT_POLL: begin
        if (it.poll_class == cfg_sel && gen_phase != PH_IDLE) begin
          on_ph   = (gen_phase == PH_ONCE_ON || gen_phase == PH_REP_ON);
          lim     = on_ph ? cfg_on_time : cfg_off_time;
          want    = on_ph ? cfg_on_val : cfg_off_val;
          elapsed = it.now_us - gen_start;
          if (elapsed >= lim) begin
            gen_start = it.now_us;
            case (gen_phase)
              PH_ONCE_ON: begin
                gen_phase = PH_ONCE_OFF;
                want      = cfg_off_val;
              end
              PH_REP_ON: begin
                gen_phase = PH_REP_OFF;
                want      = cfg_off_val;
              end
              PH_ONCE_OFF: begin
                gen_phase = PH_IDLE;
              end
              default: begin
                gen_phase = PH_REP_ON;
                want      = cfg_on_val;
              end
            endcase
          end
          if (want != drv_value) begin
            drv_value = want;
            chg       = 1'b1;
          end
        end
      end
      ACT_START_SINGLE, ACT_START_REPEAT: begin
        gen_phase = (it.action == ACT_START_SINGLE) ? PH_ONCE_ON : PH_REP_ON;
        gen_start = it.now_us;
        if (cfg_on_val != drv_value) begin
          drv_value = cfg_on_val;
          chg       = 1'b1;
        end
      end
      ACT_STOP: begin
        gen_phase = PH_IDLE;
      end
      ACT_SET_VALUE: begin
        drv_value = it.new_value;
        chg       = 1'b1;
      end
      default: begin
      end
    endcase
    r.out_value = drv_value;
    r.pin_level = (drv_value != '0) ^ cfg_invert;
    r.changed   = chg;
    r.phase     = gen_phase;
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [2:0] act,
                                         input logic [TIME_BITS-1:0] now,
                                         input logic [1:0] cls,
                                         input logic [VALUE_BITS-1:0] val);
    in_item_t it;
    it.action     = act;
    it.now_us     = now;
    it.poll_class = cls;
    it.new_value  = val;
    return it;
  endfunction

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Predict on every input transfer.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      pending_outputs.push_back(channel_next(in_data));
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t ns: result transfer with none expected, actual %0h", $time, out_data);
        errors++;
      end else begin
        want_item = pending_outputs.pop_front();
        flag_field("out_value", want_item.out_value, out_data.out_value);
        flag_field("pin_level", want_item.pin_level, out_data.pin_level);
        flag_field("changed", want_item.changed, out_data.changed);
        flag_field("phase", want_item.phase, out_data.phase);
        n_checked++;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 6);
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_outputs.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One input transfer, sometimes after a one-cycle gap.
  task automatic send_item(input in_item_t it);
    if (!no_gaps && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic issue(input logic [2:0] act, input logic [TIME_BITS-1:0] dt,
                       input logic [1:0] cls, input logic [VALUE_BITS-1:0] val);
    now_cur += dt;
    send_item(make_item(act, now_cur, cls, val));
  endtask

  // Stop sending and wait until every expected result has arrived. The
  // first edge lets the last accepted item reach the prediction queue.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write followed by a read back of the same register.
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] kept;
    case (idx)
      REG_POLL_CLASS_SEL: kept = {30'd0, val[1:0]};
      REG_ON_VALUE, REG_OFF_VALUE: kept = {24'd0, val[7:0]};
      REG_INVERT: kept = {31'd0, val[0]};
      default: kept = val;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_POLL_CLASS_SEL: cfg_sel = kept[1:0];
      REG_ON_TIME:        cfg_on_time = kept;
      REG_OFF_TIME:       cfg_off_time = kept;
      REG_ON_VALUE:       cfg_on_val = kept[7:0];
      REG_OFF_VALUE:      cfg_off_val = kept[7:0];
      default:            cfg_invert = kept[0];
    endcase
    n_writes++;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== kept) begin
      $display("%0t ns: read of register %s, expected %0h, actual %0h",
               $time, idx.name(), kept, prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_setting(input logic [1:0] sel, input logic [31:0] on_t,
                               input logic [31:0] off_t, input logic [7:0] on_v,
                               input logic [7:0] off_v, input logic inv);
    write_reg(REG_POLL_CLASS_SEL, {30'd0, sel});
    write_reg(REG_ON_TIME, on_t);
    write_reg(REG_OFF_TIME, off_t);
    write_reg(REG_ON_VALUE, {24'd0, on_v});
    write_reg(REG_OFF_VALUE, {24'd0, off_v});
    write_reg(REG_INVERT, {31'd0, inv});
    n_settings++;
  endtask

  // Mostly polls of the selected class with small time steps, mixed with
  // starts, stops, direct sets, foreign polls and fully random items.
  task automatic run_burst(input int count, input int unsigned span);
    in_item_t    it;
    int unsigned pick;
    logic [31:0] dt;
    logic [63:0] noise;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      dt   = ($urandom_range(0, 99) < 4) ? $urandom : $urandom_range(0, span);
      now_cur += dt;
      it = make_item(ACT_POLL, now_cur, cfg_sel, 8'($urandom));
      if (pick < 6) begin
        it.action = ACT_START_SINGLE;
      end else if (pick < 12) begin
        it.action = ACT_START_REPEAT;
      end else if (pick < 15) begin
        it.action = ACT_STOP;
      end else if (pick < 21) begin
        it.action = ACT_SET_VALUE;
      end else if (pick < 25) begin
        it.poll_class = 2'($urandom);
      end else if (pick < 28) begin
        noise   = {$urandom, $urandom};
        it      = noise[$bits(in_item_t)-1:0];
        now_cur = it.now_us;
      end
      send_item(it);
    end
  endtask

  // Reset values: idle polls, direct sets, unknown actions, zero durations.
  task automatic test_reset_and_direct();
    now_cur = '0;
    issue(ACT_POLL, 0, 2'd0, 8'h00);
    issue(ACT_SET_VALUE, 1, 2'd0, 8'hFF);
    issue(ACT_SET_VALUE, 1, 2'd0, 8'h00);
    issue(ACT_SET_VALUE, 1, 2'd0, 8'h00);
    issue(ACT_STOP, 1, 2'd0, 8'h00);
    issue(3'(ACT_SET_VALUE + 1), 1, 2'd1, 8'h5A);
    send_item(in_item_t'('1));
    now_cur = '0;
    issue(ACT_START_SINGLE, 1, 2'd0, 8'h00);
    issue(ACT_POLL, 0, 2'd3, 8'h00);
    issue(ACT_POLL, 0, 2'd0, 8'h00);
    issue(ACT_POLL, 0, 2'd0, 8'h00);
  endtask

  // Timed phases across the timestamp wrap, and an overwritten direct set.
  task automatic test_phase_timing();
    wait_drain();
    apply_setting(2'd2, 32'd5, 32'd3, 8'hFF, 8'h00, 1'b1);
    now_cur = 32'hFFFF_FFFC;
    issue(ACT_START_REPEAT, 0, 2'd0, 8'h00);
    issue(ACT_POLL, 4, 2'd2, 8'h00);
    issue(ACT_POLL, 1, 2'd2, 8'h00);
    issue(ACT_SET_VALUE, 0, 2'd0, 8'h42);
    issue(ACT_POLL, 1, 2'd2, 8'h00);
    issue(ACT_POLL, 2, 2'd2, 8'h00);
    issue(ACT_START_SINGLE, 0, 2'd0, 8'h00);
    issue(ACT_POLL, 5, 2'd2, 8'h00);
    issue(ACT_POLL, 3, 2'd2, 8'h00);
    issue(ACT_POLL, 1, 2'd2, 8'h00);
  endtask

  // Largest on duration: it expires only at the very last timestamp.
  task automatic test_longest_duration();
    wait_drain();
    write_reg(REG_ON_TIME, 32'hFFFF_FFFF);
    now_cur = 32'h1234_5678;
    issue(ACT_START_SINGLE, 0, 2'd0, 8'h00);
    issue(ACT_POLL, 32'hFFFF_FFFE, 2'd2, 8'h00);
    issue(ACT_POLL, 1, 2'd2, 8'h00);
  endtask

  // Random bursts under a series of settings, extremes among them.
  task automatic test_random_settings();
    for (int s = 0; s < 8; s++) begin
      wait_drain();
      case (s)
        0: apply_setting(2'd0, 32'd0, 32'd0, 8'h01, 8'h00, 1'b0);
        1: apply_setting(2'd1, 32'd7, 32'd3, 8'hFF, 8'h00, 1'b1);
        2: apply_setting(2'd2, 32'd20, 32'd40, 8'h5A, 8'hA5, 1'b0);
        3: apply_setting(2'd3, 32'd1, 32'd1, 8'h00, 8'hFF, 1'b1);
        4: apply_setting(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h80, 8'h01, 1'b0);
        5: apply_setting(2'd1, 32'h8000_0000, 32'd5, 8'h33, 8'h33, 1'b1);
        default: apply_setting(2'($urandom_range(0, 2)), $urandom_range(0, 30),
                               $urandom_range(0, 30), 8'($urandom), 8'($urandom),
                               1'($urandom));
      endcase
      // One setting runs with no idling on either side.
      no_gaps = (s == 2);
      run_burst(165, (s == 2) ? 60 : (s == 4 ? 16 : 10));
    end
    no_gaps = 1'b0;
  endtask

  // Long receiver hold-off while items keep coming, then a full pause.
  task automatic test_backpressure();
    wait_drain();
    apply_setting(2'd0, 32'd3, 32'd2, 8'hC3, 8'h3C, 1'b0);
    hold_req = 150;
    run_burst(50, 4);
    wait_drain();
    run_burst(50, 4);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_and_direct();
    test_phase_timing();
    test_longest_duration();
    test_random_settings();
    test_backpressure();
    wait_drain();
    repeat (6) @(posedge clk);
    $display("Sent %0d input transfers and checked %0d result transfers", n_sent, n_checked);
    $display("across %0d register settings and %0d register writes", n_settings, n_writes);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
design/pbot_pkg.sv
design/pulse_blink_output_timer.sv
tb/sv/pulse_blink_output_timer_test.sv
